// ----- rtl/htcbm_pkg.sv -----
// ============================================================================
// htcbm_pkg
// Shared types and constants for the hold-to-cycle button menu.
// ============================================================================
`default_nettype none

package htcbm_pkg;

    localparam int NOW_W      = 32;
    localparam int IV_W       = 16;
    localparam int HALF_W     = IV_W - 1;
    localparam int LVL_W      = 7;
    localparam int FUNC_W     = 8;
    localparam int COLOR_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // bright*(half-dist) + dark*dist stays below 128*half
    localparam int ACC_W      = HALF_W + LVL_W;
    localparam int DIV_STEPS  = NOW_W;
    localparam int MUL_STEPS  = LVL_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd3;

    localparam logic [LVL_W-1:0] RST_BRIGHT   = 7'd100;
    localparam logic [LVL_W-1:0] RST_DARK     = 7'd0;
    localparam logic [IV_W-1:0]  RST_INTERVAL = 16'd1000;
    localparam logic [IV_W-1:0]  RST_TIMEOUT  = 16'd5000;

    localparam logic [LVL_W-1:0]   BRG_START   = 7'd100;
    localparam logic [LVL_W-1:0]   BRG_RELEASE = 7'd80;
    localparam logic [LVL_W-1:0]   BRG_MAX     = 7'd100;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 3'd4;
    localparam logic [FUNC_W-1:0]  FUNC_MAX    = 8'd255;

    typedef struct packed {
        logic               color_valid;
        logic [COLOR_W-1:0] color;
        logic               brightness_valid;
        logic [LVL_W-1:0]   brightness;
        logic               event_valid;
        logic [FUNC_W-1:0]  event_func;
        logic               sched_valid;
        logic               sched_enable;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/htcbm_in_if.sv -----
// ============================================================================
// htcbm_in_if
// Button sample channel: level and millisecond timestamp.
// ============================================================================
`default_nettype none

interface htcbm_in_if
    import htcbm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             pressed;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, pressed, now_ms, input ready);
    modport sink (input valid, pressed, now_ms, output ready);
endinterface

`default_nettype wire

// ----- rtl/htcbm_out_if.sv -----
// ============================================================================
// htcbm_out_if
// Result channel: LED, event and scheduling commands for one sample.
// ============================================================================
`default_nettype none

interface htcbm_out_if
    import htcbm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               color_valid;
    logic [COLOR_W-1:0] color;
    logic               brightness_valid;
    logic [LVL_W-1:0]   brightness;
    logic               event_valid;
    logic [FUNC_W-1:0]  event_func;
    logic               sched_valid;
    logic               sched_enable;

    modport source (
        output valid, color_valid, color, brightness_valid, brightness,
               event_valid, event_func, sched_valid, sched_enable,
        input  ready
    );
    modport sink (
        input  valid, color_valid, color, brightness_valid, brightness,
               event_valid, event_func, sched_valid, sched_enable,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/hold_to_cycle_button_menu.sv -----
// ============================================================================
// hold_to_cycle_button_menu
// Single-button menu sequencer with bit-serial divide and multiply.
// ============================================================================
// Usage:
//   i_sample takes one word per button sample (pressed, now_ms); o_result
//   gives exactly one word per sample with color, brightness, event and
//   scheduling commands. Registers are written through i_cfg_we/i_cfg_idx/
//   i_cfg_data; the user is to write them only while the block is idle,
//   and the block itself does not enforce this. Most samples go from accept
//   through S_PUSH into the output register. A sample taken while the button
//   is held in cycle mode runs a 32-step restoring divide of the hold time
//   by the interval, one quotient bit per cycle, then a 7-step shift-add for
//   the brightness triangle and a 7-step divide by half the interval, before
//   S_PUSH. i_sample.ready is high only while no sample is in work, so a new
//   sample is not taken before the last one is in the output register.
//   Reset (synchronous, active low) returns to menu idle, loads register
//   defaults and empties the output register.
//   A stalled receiver holds the output word; the next sample is still
//   accepted and worked on, and its word waits until the output frees up.
// ============================================================================
`default_nettype none

module hold_to_cycle_button_menu
    import htcbm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    htcbm_in_if.sink                   i_sample,
    htcbm_out_if.source                o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_FUNC, S_MUL, S_QDIV, S_PUSH
    } t_state;

    typedef enum logic [1:0] {
        MODE_IDLE, MODE_CYCLE, MODE_CONFIRM, MODE_EXECUTED
    } t_mode;

    t_state             r_state;
    t_mode              r_mode;
    logic [LVL_W-1:0]   r_bright;
    logic [LVL_W-1:0]   r_dark;
    logic [IV_W-1:0]    r_interval;
    logic [IV_W-1:0]    r_timeout;
    logic [NOW_W-1:0]   r_press_start;
    logic [NOW_W-1:0]   r_release_time;
    logic [FUNC_W-1:0]  r_chosen_func;
    logic               r_chosen_valid;
    logic [CNT_W-1:0]   r_cnt;
    logic [NOW_W-1:0]   r_dq;
    logic [IV_W-1:0]    r_drem;
    logic [HALF_W-1:0]  r_half;
    logic [ACC_W-1:0]   r_ma;
    logic [ACC_W-1:0]   r_md;
    logic [LVL_W-1:0]   r_mb;
    logic [LVL_W-1:0]   r_mk;
    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   r_dv;
    logic [LVL_W-1:0]   r_q;
    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;

    logic               in_acc;
    logic               out_free;
    logic [IV_W-1:0]    iv;
    logic [HALF_W-1:0]  half;
    logic [IV_W:0]      div_t;
    logic               div_ge;
    logic [IV_W:0]      div_sub;
    logic [IV_W-1:0]    n_drem;
    logic [FUNC_W-1:0]  f_sat;
    logic               new_func;
    logic [IV_W-1:0]    dist_w;
    logic [HALF_W-1:0]  tri_dist;
    logic [ACC_W-1:0]   mul_add;
    logic               qd_ge;
    logic [LVL_W-1:0]   q_fin;
    logic [LVL_W-1:0]   brg_raw;
    logic [LVL_W-1:0]   brg_fin;
    logic [NOW_W-1:0]   elapsed;
    t_result            imm;
    t_result            func_res;
    t_result            brg_res;
    t_mode              imm_mode;
    logic               go_div;
    logic               set_press;
    logic               set_rel;
    logic               fin;

    assign in_acc         = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == S_IDLE);
    assign out_free       = !r_out_valid || o_result.ready;

    assign iv      = (r_interval == '0) ? IV_W'(1) : r_interval;
    assign half    = iv[IV_W-1:1];

    // restoring divide step: quotient bits shift into r_dq behind the dividend
    assign div_t   = {r_drem, r_dq[NOW_W-1]};
    assign div_ge  = div_t >= {1'b0, iv};
    assign div_sub = div_t - {1'b0, iv};
    assign n_drem  = div_ge ? div_sub[IV_W-1:0] : div_t[IV_W-1:0];

    assign f_sat    = (|r_dq[NOW_W-1:FUNC_W]) ? FUNC_MAX : r_dq[FUNC_W-1:0];
    assign new_func = !r_chosen_valid || (f_sat != r_chosen_func);
    assign dist_w   = ({1'b0, half} >= r_drem) ? ({1'b0, half} - r_drem)
                                               : (r_drem - {1'b0, half});
    assign tri_dist = dist_w[HALF_W-1:0];

    assign mul_add = (r_mb[0] ? r_ma : '0) + (r_mk[0] ? r_md : '0);
    assign qd_ge   = r_acc >= r_dv;
    assign q_fin   = {r_q[LVL_W-2:0], qd_ge};
    assign brg_raw = (r_half == '0) ? r_bright : q_fin;
    assign brg_fin = (brg_raw > BRG_MAX) ? BRG_MAX : brg_raw;

    assign elapsed = i_sample.now_ms - r_release_time;

    always_comb begin
        func_res = '0;
        if (new_func) begin
            func_res.color_valid = 1'b1;
            func_res.color       = {1'b0, f_sat[1:0]};
        end
        brg_res                  = r_res;
        brg_res.brightness_valid = 1'b1;
        brg_res.brightness       = brg_fin;
    end

    always_comb begin
        imm       = '0;
        imm_mode  = r_mode;
        go_div    = 1'b0;
        set_press = 1'b0;
        set_rel   = 1'b0;
        fin       = 1'b0;
        if (i_sample.pressed) begin
            unique case (r_mode)
                MODE_IDLE: begin
                    imm.sched_valid      = 1'b1;
                    imm.brightness_valid = 1'b1;
                    imm.brightness       = BRG_START;
                    set_press            = 1'b1;
                    imm_mode             = MODE_CYCLE;
                end
                MODE_CYCLE: begin
                    go_div = 1'b1;
                end
                MODE_CONFIRM: begin
                    set_press       = 1'b1;
                    imm.event_valid = 1'b1;
                    imm.event_func  = r_chosen_func;
                    imm_mode        = MODE_EXECUTED;
                end
                MODE_EXECUTED: begin
                end
            endcase
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                end
                MODE_CYCLE: begin
                    if (r_chosen_valid) begin
                        imm.color_valid      = 1'b1;
                        imm.color            = {1'b0, r_chosen_func[1:0]};
                        imm.brightness_valid = 1'b1;
                        imm.brightness       = BRG_RELEASE;
                        set_rel              = 1'b1;
                        imm_mode             = MODE_CONFIRM;
                    end else begin
                        fin = 1'b1;
                    end
                end
                MODE_CONFIRM: begin
                    if (elapsed >= {{(NOW_W-IV_W){1'b0}}, r_timeout}) begin
                        fin = 1'b1;
                    end
                end
                MODE_EXECUTED: begin
                    fin = 1'b1;
                end
            endcase
        end
        if (fin) begin
            imm.color_valid  = 1'b1;
            imm.color        = COLOR_BLACK;
            imm.sched_valid  = 1'b1;
            imm.sched_enable = 1'b1;
            imm_mode         = MODE_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_mode         <= MODE_IDLE;
            r_bright       <= RST_BRIGHT;
            r_dark         <= RST_DARK;
            r_interval     <= RST_INTERVAL;
            r_timeout      <= RST_TIMEOUT;
            r_press_start  <= '0;
            r_release_time <= '0;
            r_chosen_func  <= '0;
            r_chosen_valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BRIGHT:   r_bright   <= i_cfg_data[LVL_W-1:0];
                    CFG_DARK:     r_dark     <= i_cfg_data[LVL_W-1:0];
                    CFG_INTERVAL: r_interval <= i_cfg_data[IV_W-1:0];
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data[IV_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cnt <= '0;
                        if (go_div) begin
                            r_dq    <= i_sample.now_ms - r_press_start;
                            r_drem  <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_res   <= imm;
                            r_mode  <= imm_mode;
                            r_state <= S_PUSH;
                            if (set_press) begin
                                r_press_start <= i_sample.now_ms;
                            end
                            if (set_rel) begin
                                r_release_time <= i_sample.now_ms;
                            end
                            if (fin) begin
                                r_release_time <= '0;
                                r_chosen_valid <= 1'b0;
                            end
                        end
                    end
                end
                S_DIV: begin
                    r_drem <= n_drem;
                    r_dq   <= {r_dq[NOW_W-2:0], div_ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_FUNC;
                    end
                end
                S_FUNC: begin
                    r_res <= func_res;
                    if (new_func) begin
                        r_chosen_func  <= f_sat;
                        r_chosen_valid <= 1'b1;
                    end
                    r_half  <= half;
                    r_ma    <= ACC_W'(half - tri_dist);
                    r_md    <= ACC_W'(tri_dist);
                    r_mb    <= r_bright;
                    r_mk    <= r_dark;
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= r_acc + mul_add;
                    r_ma  <= {r_ma[ACC_W-2:0], 1'b0};
                    r_md  <= {r_md[ACC_W-2:0], 1'b0};
                    r_mb  <= {1'b0, r_mb[LVL_W-1:1]};
                    r_mk  <= {1'b0, r_mk[LVL_W-1:1]};
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_dv    <= ACC_W'({r_half, {(LVL_W-1){1'b0}}});
                        r_cnt   <= '0;
                        r_state <= S_QDIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_QDIV: begin
                    if (qd_ge) begin
                        r_acc <= r_acc - r_dv;
                    end
                    r_q   <= q_fin;
                    r_dv  <= {1'b0, r_dv[ACC_W-1:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_res   <= brg_res;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.color_valid      = r_out.color_valid;
    assign o_result.color            = r_out.color;
    assign o_result.brightness_valid = r_out.brightness_valid;
    assign o_result.brightness       = r_out.brightness;
    assign o_result.event_valid      = r_out.event_valid;
    assign o_result.event_func       = r_out.event_func;
    assign o_result.sched_valid      = r_out.sched_valid;
    assign o_result.sched_enable     = r_out.sched_enable;

    a_idle_no_choice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> !r_chosen_valid)
        else $error("menu idle with a function still chosen");

    a_held_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_sample.pressed && r_mode == MODE_CYCLE) |=> (r_state == S_DIV))
        else $error("held sample did not start the divider");

    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.color_valid) |-> (o_result.color <= COLOR_BLACK))
        else $error("color code out of range");

    a_brg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.brightness_valid) |-> (o_result.brightness <= BRG_MAX))
        else $error("brightness above full scale");

endmodule

`default_nettype wire

// ----- sim/hold_to_cycle_button_menu_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hold_to_cycle_button_menu_tb
// Self-checking bench for the single-button menu. Button samples are driven
// as a short table of directed steps and then as random press/hold/release
// sessions under several register settings. A behavioral copy of the menu
// computes the command word for every accepted sample, and each output word
// is compared with the oldest pending command, field by field.
// ----------------------------------------------------------------------------

module hold_to_cycle_button_menu_tb;
    import htcbm_pkg::*;

    localparam int PHASE_WORDS  = 150;
    localparam int NUM_PHASES   = 8;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLDOFF_LEN  = 400;

    typedef enum logic [1:0] {
        MENU_IDLE     = 2'd0,
        MENU_CYCLE    = 2'd1,
        MENU_CONFIRM  = 2'd2,
        MENU_EXECUTED = 2'd3
    } t_menu_mode;

    typedef struct {
        logic        pressed;
        logic [31:0] now;
        bit          fixed;
        t_result     res;
    } t_step_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    htcbm_in_if  sample_if ();
    htcbm_out_if result_if ();

    hold_to_cycle_button_menu dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_if),
        .o_result   (result_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow registers and menu state
    logic [LVL_W-1:0]  cfg_bright;
    logic [LVL_W-1:0]  cfg_dark;
    logic [IV_W-1:0]   cfg_interval;
    logic [IV_W-1:0]   cfg_timeout;
    t_menu_mode        menu_mode;
    logic [31:0]       press_t;
    logic [31:0]       rel_t;
    logic [FUNC_W-1:0] shown_func;
    bit                shown;

    t_result     cmd_expect_q[$];
    t_step_row   dir_rows[$];
    logic        word_fixed;
    t_result     word_fixed_res;
    bit          src_idle_en;
    bit          sink_idle_en;
    bit          holdoff_req;
    int          err_cnt;
    int          words_sent;
    int          quiet_cycles;
    logic [31:0] ms_clock;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [LVL_W-1:0] triangle_level(logic [31:0] rem, logic [31:0] half);
        longint span, num, lvl;
        if (half == 0) begin
            lvl = longint'(cfg_bright);
        end else begin
            span = longint'(half) - longint'(rem);
            if (span < 0) span = -span;
            num = longint'(cfg_bright) * longint'(half)
                + span * (longint'(cfg_dark) - longint'(cfg_bright));
            if (num < 0) num = 0;
            lvl = num / longint'(half);
        end
        if (lvl > 100) lvl = 100;
        return lvl[LVL_W-1:0];
    endfunction

    function automatic t_result menu_predict(logic pr, logic [31:0] t);
        t_result     r;
        logic [31:0] iv, hold, fn, since;
        bit          finish;
        r = '0;
        finish = 1'b0;
        if (pr) begin
            case (menu_mode)
                MENU_IDLE: begin
                    r.sched_valid      = 1'b1;
                    r.sched_enable     = 1'b0;
                    r.brightness_valid = 1'b1;
                    r.brightness       = BRG_START;
                    press_t            = t;
                    menu_mode          = MENU_CYCLE;
                end
                MENU_CYCLE: begin
                    iv   = (cfg_interval == 0) ? 32'd1 : {16'd0, cfg_interval};
                    hold = t - press_t;
                    fn   = hold / iv;
                    if (fn > FUNC_MAX) fn = FUNC_MAX;
                    if (!shown || fn[FUNC_W-1:0] != shown_func) begin
                        r.color_valid = 1'b1;
                        r.color       = {1'b0, fn[1:0]};
                        shown_func    = fn[FUNC_W-1:0];
                        shown         = 1'b1;
                    end
                    r.brightness_valid = 1'b1;
                    r.brightness       = triangle_level(hold % iv, iv / 2);
                end
                MENU_CONFIRM: begin
                    press_t       = t;
                    r.event_valid = 1'b1;
                    r.event_func  = shown_func;
                    menu_mode     = MENU_EXECUTED;
                end
                default: ;
            endcase
        end else begin
            case (menu_mode)
                MENU_CYCLE: begin
                    if (shown) begin
                        r.color_valid      = 1'b1;
                        r.color            = {1'b0, shown_func[1:0]};
                        r.brightness_valid = 1'b1;
                        r.brightness       = BRG_RELEASE;
                        rel_t              = t;
                        menu_mode          = MENU_CONFIRM;
                    end else begin
                        finish = 1'b1;
                    end
                end
                MENU_CONFIRM: begin
                    since = t - rel_t;
                    if (since >= {16'd0, cfg_timeout}) finish = 1'b1;
                end
                MENU_EXECUTED: finish = 1'b1;
                default: ;
            endcase
        end
        if (finish) begin
            r.color_valid  = 1'b1;
            r.color        = COLOR_BLACK;
            r.sched_valid  = 1'b1;
            r.sched_enable = 1'b1;
            rel_t          = '0;
            shown          = 1'b0;
            menu_mode      = MENU_IDLE;
        end
        return r;
    endfunction

    function automatic t_result cmd(bit cv, logic [2:0] col, bit bv, logic [6:0] brg,
                                    bit ev, logic [7:0] ef, bit sv, bit se);
        t_result r;
        r.color_valid      = cv;
        r.color            = col;
        r.brightness_valid = bv;
        r.brightness       = brg;
        r.event_valid      = ev;
        r.event_func       = ef;
        r.sched_valid      = sv;
        r.sched_enable     = se;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // scoreboard and watchdog
    always @(posedge i_clk) begin
        t_result pred, want;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (cmd_expect_q.size() == 0) begin
                    $error("result word with no pending command");
                    err_cnt++;
                end else begin
                    want = cmd_expect_q.pop_front();
                    check_field("color_valid", want.color_valid, result_if.color_valid);
                    check_field("color", want.color, result_if.color);
                    check_field("brightness_valid", want.brightness_valid,
                                result_if.brightness_valid);
                    check_field("brightness", want.brightness, result_if.brightness);
                    check_field("event_valid", want.event_valid, result_if.event_valid);
                    check_field("event_func", want.event_func, result_if.event_func);
                    check_field("sched_valid", want.sched_valid, result_if.sched_valid);
                    check_field("sched_enable", want.sched_enable, result_if.sched_enable);
                end
            end
            if (sample_if.valid && sample_if.ready) begin
                pred = menu_predict(sample_if.pressed, sample_if.now_ms);
                cmd_expect_q.push_back(word_fixed ? word_fixed_res : pred);
            end
            if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("hold_to_cycle_button_menu: mismatch");
                $finish;
            end
        end
    end

    // receiver: random back-pressure bursts and one long hold-off
    initial begin
        int burst;
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req) begin
                result_if.ready <= 1'b0;
                repeat (HOLDOFF_LEN - 1) @(negedge i_clk);
                holdoff_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 6);
                result_if.ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(logic pr, logic [31:0] t, bit fixed, t_result res);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            sample_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        sample_if.valid   <= 1'b1;
        sample_if.pressed <= pr;
        sample_if.now_ms  <= t;
        word_fixed        <= fixed;
        word_fixed_res    <= res;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic wait_drained(bit settle);
        @(negedge i_clk);
        sample_if.valid <= 1'b0;
        while (cmd_expect_q.size() != 0) @(posedge i_clk);
        if (settle) repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_BRIGHT:   cfg_bright   = data[LVL_W-1:0];
            CFG_DARK:     cfg_dark     = data[LVL_W-1:0];
            CFG_INTERVAL: cfg_interval = data;
            CFG_TIMEOUT:  cfg_timeout  = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_row(logic pr, logic [31:0] t, bit fixed, t_result res);
        t_step_row row;
        row.pressed = pr;
        row.now     = t;
        row.fixed   = fixed;
        row.res     = res;
        dir_rows.push_back(row);
    endtask

    // press, hold a while, release, then confirm, time out or add noise
    task automatic run_session();
        logic [31:0] iv, tmo, rel_ms;
        int          path;
        iv  = (cfg_interval == 0) ? 32'd1 : {16'd0, cfg_interval};
        tmo = {16'd0, cfg_timeout};
        if ($urandom_range(0, 19) == 0) ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 3 * iv);
        ms_clock += $urandom_range(0, 50);
        send_word(1'b1, ms_clock, 1'b0, '0);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 15))
                0:       ms_clock += $urandom_range(0, 300 * iv);
                1:       ms_clock += $urandom;
                default: ms_clock += $urandom_range(0, iv + iv / 2);
            endcase
            send_word(1'b1, ms_clock, 1'b0, '0);
        end
        ms_clock += $urandom_range(0, 3);
        rel_ms = ms_clock;
        send_word(1'b0, ms_clock, 1'b0, '0);
        path = $urandom_range(0, 9);
        if (path < 5) begin
            ms_clock = rel_ms + ((tmo == 0) ? 32'd0 : $urandom_range(0, tmo - 1));
            send_word(1'b1, ms_clock, 1'b0, '0);
            repeat ($urandom_range(0, 2)) begin
                ms_clock += $urandom_range(0, iv);
                send_word(1'b1, ms_clock, 1'b0, '0);
            end
            ms_clock += $urandom_range(0, iv);
            send_word(1'b0, ms_clock, 1'b0, '0);
        end else if (path < 8) begin
            repeat ($urandom_range(0, 2)) begin
                ms_clock = rel_ms + ((tmo == 0) ? 32'd0 : $urandom_range(0, tmo - 1));
                send_word(1'b0, ms_clock, 1'b0, '0);
            end
            ms_clock = rel_ms + tmo + $urandom_range(0, 3);
            send_word(1'b0, ms_clock, 1'b0, '0);
        end else begin
            repeat ($urandom_range(1, 4)) begin
                ms_clock += $urandom_range(0, 2 * iv);
                send_word(1'($urandom_range(0, 1)),
                          ($urandom_range(0, 3) == 0) ? $urandom : ms_clock, 1'b0, '0);
            end
        end
    endtask

    initial begin
        int unsigned ph_bright[NUM_PHASES]   = '{100, 0, 127, 100, 50, 3, 0, 80};
        int unsigned ph_dark[NUM_PHASES]     = '{0, 100, 127, 0, 20, 90, 0, 10};
        int unsigned ph_interval[NUM_PHASES] = '{1000, 2, 65535, 0, 1, 7, 0, 16};
        int unsigned ph_timeout[NUM_PHASES]  = '{5000, 0, 65535, 10, 3, 100, 0, 40};
        int          phase_end;
        bit          paused;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        sample_if.valid   = 1'b0;
        sample_if.pressed = 1'b0;
        sample_if.now_ms  = '0;
        word_fixed        = 1'b0;
        word_fixed_res    = '0;
        src_idle_en       = 1'b1;
        sink_idle_en      = 1'b1;
        holdoff_req       = 1'b0;
        err_cnt           = 0;
        words_sent        = 0;
        cfg_bright        = RST_BRIGHT;
        cfg_dark          = RST_DARK;
        cfg_interval      = RST_INTERVAL;
        cfg_timeout       = RST_TIMEOUT;
        menu_mode         = MENU_IDLE;
        press_t           = '0;
        rel_t             = '0;
        shown_func        = '0;
        shown             = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed steps on reset registers: confirm path, repair, saturation, wrap
        add_row(1'b0, 32'd0,      1'b1, '0);
        add_row(1'b1, 32'd100,    1'b1, cmd(0, 0, 1, 100, 0, 0, 1, 0));
        add_row(1'b1, 32'd100,    1'b1, cmd(1, 0, 1, 0, 0, 0, 0, 0));
        add_row(1'b1, 32'd600,    1'b1, cmd(0, 0, 1, 100, 0, 0, 0, 0));
        add_row(1'b1, 32'd1100,   1'b0, '0);
        add_row(1'b1, 32'd2350,   1'b0, '0);
        add_row(1'b1, 32'd3999,   1'b0, '0);
        add_row(1'b0, 32'd4000,   1'b1, cmd(1, 3, 1, 80, 0, 0, 0, 0));
        add_row(1'b0, 32'd4001,   1'b1, '0);
        add_row(1'b1, 32'd5000,   1'b1, cmd(0, 0, 0, 0, 1, 3, 0, 0));
        add_row(1'b1, 32'd5001,   1'b1, '0);
        add_row(1'b0, 32'd5002,   1'b1, cmd(1, COLOR_BLACK, 0, 0, 0, 0, 1, 1));
        add_row(1'b1, 32'd10000,  1'b0, '0);
        add_row(1'b0, 32'd10001,  1'b1, cmd(1, COLOR_BLACK, 0, 0, 0, 0, 1, 1));
        add_row(1'b1, 32'd20000,  1'b0, '0);
        add_row(1'b1, 32'd320000, 1'b0, '0);
        add_row(1'b1, 32'd400000, 1'b0, '0);
        add_row(1'b0, 32'd400001, 1'b0, '0);
        add_row(1'b0, 32'd405001, 1'b0, '0);
        add_row(1'b1, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(1'b1, 32'h0000_0400, 1'b0, '0);
        add_row(1'b0, 32'h0000_0500, 1'b0, '0);
        add_row(1'b1, 32'h0000_0600, 1'b0, '0);
        add_row(1'b0, 32'h0000_0601, 1'b0, '0);
        foreach (dir_rows[i])
            send_word(dir_rows[i].pressed, dir_rows[i].now, dir_rows[i].fixed, dir_rows[i].res);
        wait_drained(1'b1);
        ms_clock = 32'h0000_1000;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 6) begin
                ph_bright[ph]   = $urandom_range(0, 127);
                ph_dark[ph]     = $urandom_range(0, 127);
                ph_interval[ph] = $urandom_range(0, 300);
                ph_timeout[ph]  = $urandom_range(0, 600);
            end
            write_reg(CFG_BRIGHT, CFG_DATA_W'(ph_bright[ph]));
            write_reg(CFG_DARK, CFG_DATA_W'(ph_dark[ph]));
            write_reg(CFG_INTERVAL, CFG_DATA_W'(ph_interval[ph]));
            write_reg(CFG_TIMEOUT, CFG_DATA_W'(ph_timeout[ph]));
            src_idle_en  = (ph != 5) && (ph != NUM_PHASES - 1);
            sink_idle_en = (ph != 5) && (ph != NUM_PHASES - 1);
            if (ph == 2) holdoff_req = 1'b1;
            phase_end = words_sent + PHASE_WORDS;
            paused    = 1'b0;
            while (words_sent < phase_end) begin
                run_session();
                if (ph == 4 && !paused && words_sent > phase_end - PHASE_WORDS / 2) begin
                    wait_drained(1'b0);
                    paused = 1'b1;
                end
            end
            wait_drained(1'b1);
        end

        if (cmd_expect_q.size() != 0) begin
            $error("%0d commands never arrived", cmd_expect_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("hold_to_cycle_button_menu: match");
        end else begin
            $display("hold_to_cycle_button_menu: mismatch");
        end
        $finish;
    end

endmodule
